// ----- hdl/rgb565_to_cielab_top_macros.svh -----
// ---------------------------------------------------------------------------
// rgb565_to_cielab_top_macros: assertion macros
// Concurrent checks that vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef RGB565_TO_CIELAB_TOP_MACROS_SVH
`define RGB565_TO_CIELAB_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RGBLAB_CHECK_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RGBLAB_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RGBLAB_CHECK_NOW(lbl, clk, rst, ante, cons, msg)

`define RGBLAB_CHECK_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hdl/rgblab_pkg.sv -----
// ---------------------------------------------------------------------------
// rgblab_pkg: shared functions for the rgb565 to cielab converter
// Elaboration-time builders for the linearization and cube-root tables.
// ---------------------------------------------------------------------------
package rgblab_pkg;

  // q30 value rounded half up to frac_bits fraction bits
  function automatic longint unsigned to_frac(input longint unsigned q30, input int frac_bits);
    return (q30 + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
  endfunction

  // truncated fifth power in q30
  function automatic longint unsigned pow5_q30(input longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  // truncated cube in q30
  function automatic longint unsigned cube_q30(input longint unsigned y);
    return (((y * y) >> 30) * y) >> 30;
  endfunction

  // srgb linearization of one 8-bit code, q1.frac_bits
  function automatic longint unsigned lin_value(input longint unsigned c8, input int frac_bits);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (c8 <= 10) begin
      return (((c8 * 100) << frac_bits) + 164730) / 329460;
    end
    u  = (((1000 * c8 + 14025) << 30) + 134512) / 269025;
    u2 = (u * u) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (pow5_q30(mid) <= u2) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return to_frac((u2 * lo) >> 30, frac_bits);
  endfunction

  // cube root of k * 2^-root_bits, q.frac_bits
  function automatic longint unsigned root_value(input longint unsigned k, input int frac_bits,
                                                 input int root_bits);
    longint unsigned target;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    target = k << (30 - root_bits);
    lo = 0;
    hi = (64'd1 << 31) - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (cube_q30(mid) <= target) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return to_frac(lo, frac_bits);
  endfunction

endpackage

// ----- hdl/rgb565_to_cielab_top.sv -----
// ---------------------------------------------------------------------------
// rgb565_to_cielab_top: byte-swapped rgb565 pixel to cielab l, a, b
// pipelined from input transaction to result; one pixel per clock while out_ready allows
// per-stage valid bits fill bubbles; a stalled result holds only stages behind it
// rst clears the valid bits only; all tables are constants, no clearing pass
// ---------------------------------------------------------------------------
`include "rgb565_to_cielab_top_macros.svh"

module rgb565_to_cielab_top #(
  parameter int FRAC_BITS       = 16,
  parameter int ROOT_TABLE_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        lightness,
  output logic signed [7:0] green_red,
  output logic signed [7:0] blue_yellow
);

  localparam int F     = FRAC_BITS;
  localparam int R     = ROOT_TABLE_BITS;
  localparam int NW    = F + 17;
  localparam int VW    = F + 12;
  localparam int OW    = VW - F;
  localparam int NST   = 11;
  localparam int S_LUT = 0;
  localparam int S_MIX = 1;
  localparam int S_DIV = 2;
  localparam int S_F   = 5;
  localparam int S_MUL = 9;
  localparam int S_OUT = 10;

  localparam logic signed [VW-1:0] K116   = VW'(116);
  localparam logic signed [VW-1:0] K500   = VW'(500);
  localparam logic signed [VW-1:0] K200   = VW'(200);
  localparam logic signed [VW-1:0] L_OFS  = VW'(64'd16 << F);
  localparam logic signed [VW-1:0] HALF   = VW'(64'd1 << (F - 1));
  localparam logic signed [OW-1:0] L_MAX  = OW'(100);
  localparam logic signed [OW-1:0] B_MAX  = OW'(127);
  localparam logic signed [OW-1:0] B_MIN  = OW'(-128);
  localparam logic signed [OW-1:0] O_ZERO = OW'(0);

  logic [NST-1:0] v;
  logic [NST:0]   adv;

  logic [4:0]  r_code;
  logic [5:0]  g_code;
  logic [4:0]  b_code;
  logic [F:0]  lin_rb [32];
  logic [F:0]  lin_g  [64];
  logic [F:0]  rl_s0;
  logic [F:0]  gl_s0;
  logic [F:0]  bl_s0;
  logic [NW-1:0] nx_s1;
  logic [NW-1:0] ny_s1;
  logic [NW-1:0] nz_s1;
  logic [F:0]  xq;
  logic [F:0]  yq;
  logic [F:0]  zq;
  logic [F:0]  fx;
  logic [F:0]  fy;
  logic [F:0]  fz;
  logic signed [VW-1:0] fx_w;
  logic signed [VW-1:0] fy_w;
  logic signed [VW-1:0] fz_w;
  logic signed [VW-1:0] vl_s9;
  logic signed [VW-1:0] va_s9;
  logic signed [VW-1:0] vb_s9;
  logic signed [OW-1:0] lq;
  logic signed [OW-1:0] aq;
  logic signed [OW-1:0] bq;
  logic [6:0]        light_next;
  logic signed [7:0] a_next;
  logic signed [7:0] b_next;

  // stage advance: a stage moves when empty or when the one after it moves
  always_comb begin
    adv[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[S_LUT];
  assign out_valid = v[S_OUT];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // linearization tables, one per channel depth
  for (genvar k = 0; k < 32; k++) begin : g_lin_rb
    localparam int              C8  = (k * 255) / 31;
    localparam longint unsigned VAL = rgblab_pkg::lin_value(C8, F);
    assign lin_rb[k] = (F + 1)'(VAL);
  end

  for (genvar k = 0; k < 64; k++) begin : g_lin_g
    localparam int              C8  = (k * 255) / 63;
    localparam longint unsigned VAL = rgblab_pkg::lin_value(C8, F);
    assign lin_g[k] = (F + 1)'(VAL);
  end

  // unpack the byte-swapped pixel
  assign r_code = pixel[7:3];
  assign g_code = {pixel[2:0], pixel[15:13]};
  assign b_code = pixel[12:8];

  always_ff @(posedge clk) begin
    if (adv[S_LUT]) begin
      rl_s0 <= lin_rb[r_code];
      gl_s0 <= lin_g[g_code];
      bl_s0 <= lin_rb[b_code];
    end
  end

  // d65 matrix with white scaling folded into the numerators
  always_ff @(posedge clk) begin
    if (adv[S_MIX]) begin
      nx_s1 <= NW'(41240) * NW'(rl_s0) + NW'(35760) * NW'(gl_s0)
             + NW'(18050) * NW'(bl_s0) + NW'(47523);
      ny_s1 <= NW'(2126) * NW'(rl_s0) + NW'(7152) * NW'(gl_s0)
             + NW'(722) * NW'(bl_s0) + NW'(5000);
      nz_s1 <= NW'(1930) * NW'(rl_s0) + NW'(11920) * NW'(gl_s0)
             + NW'(95050) * NW'(bl_s0) + NW'(54441);
    end
  end

  // normalize to the white point
  rgblab_cdiv #(.NW(NW), .DIV(95047), .QW(F + 1)) u_div_x (
    .clk (clk), .adv (adv[S_DIV +: 3]), .num (nx_s1), .quo (xq)
  );

  rgblab_cdiv #(.NW(NW), .DIV(10000), .QW(F + 1)) u_div_y (
    .clk (clk), .adv (adv[S_DIV +: 3]), .num (ny_s1), .quo (yq)
  );

  rgblab_cdiv #(.NW(NW), .DIV(108883), .QW(F + 1)) u_div_z (
    .clk (clk), .adv (adv[S_DIV +: 3]), .num (nz_s1), .quo (zq)
  );

  // cielab f() per axis
  rgblab_labf #(.F(F), .R(R)) u_f_x (
    .clk (clk), .adv (adv[S_F +: 4]), .t (xq), .f (fx)
  );

  rgblab_labf #(.F(F), .R(R)) u_f_y (
    .clk (clk), .adv (adv[S_F +: 4]), .t (yq), .f (fy)
  );

  rgblab_labf #(.F(F), .R(R)) u_f_z (
    .clk (clk), .adv (adv[S_F +: 4]), .t (zq), .f (fz)
  );

  // scale, with the rounding half folded in
  assign fx_w = $signed(VW'(fx));
  assign fy_w = $signed(VW'(fy));
  assign fz_w = $signed(VW'(fz));

  always_ff @(posedge clk) begin
    if (adv[S_MUL]) begin
      vl_s9 <= fy_w * K116 - L_OFS + HALF;
      va_s9 <= (fx_w - fy_w) * K500 + HALF;
      vb_s9 <= (fy_w - fz_w) * K200 + HALF;
    end
  end

  // floor by arithmetic shift, then clamp
  assign lq = vl_s9[VW-1:F];
  assign aq = va_s9[VW-1:F];
  assign bq = vb_s9[VW-1:F];

  always_comb begin
    if (lq < O_ZERO) begin
      light_next = '0;
    end else if (lq > L_MAX) begin
      light_next = 7'd100;
    end else begin
      light_next = lq[6:0];
    end
    if (aq > B_MAX) begin
      a_next = 8'sd127;
    end else if (aq < B_MIN) begin
      a_next = -8'sd128;
    end else begin
      a_next = aq[7:0];
    end
    if (bq > B_MAX) begin
      b_next = 8'sd127;
    end else if (bq < B_MIN) begin
      b_next = -8'sd128;
    end else begin
      b_next = bq[7:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      lightness   <= light_next;
      green_red   <= a_next;
      blue_yellow <= b_next;
    end
  end

  // checks
  `RGBLAB_CHECK_NOW(a_light_range, clk, rst, out_valid, lightness <= 7'd100, "lightness above 100")
  `RGBLAB_CHECK_NEXT(a_accept_loads, clk, rst, in_valid && in_ready, v[S_LUT], "accepted pixel lost")
  `RGBLAB_CHECK_NOW(a_empty_ready, clk, rst, !v[S_OUT], in_ready, "input stalled with free output stage")

endmodule

// ----- hdl/rgblab_cdiv.sv -----
// ---------------------------------------------------------------------------
// rgblab_cdiv: pipelined divide by a constant
// Reciprocal estimate, multiply back, then up to two corrections.
// ---------------------------------------------------------------------------
module rgblab_cdiv #(
  parameter int              NW  = 33,
  parameter longint unsigned DIV = 10000,
  parameter int              QW  = 17
) (
  input  logic          clk,
  input  logic [2:0]    adv,
  input  logic [NW-1:0] num,
  output logic [QW-1:0] quo
);

  localparam int              T    = $clog2(DIV) - 1;
  localparam int              K    = NW + 1;
  localparam longint unsigned MVAL = (64'd1 << K) / DIV;
  localparam int              MW   = $clog2(MVAL + 1);
  localparam int              HW   = NW - T;
  localparam int              DW   = $clog2(DIV + 1);
  localparam int              EW   = HW + MW;
  localparam int              PW   = HW + DW;
  localparam logic [MW-1:0]   MREC = MW'(MVAL);

  logic [EW-1:0] est_full;
  logic [EW-1:0] est_shift;
  logic [HW-1:0] qe_a;
  logic [NW-1:0] num_a;
  logic [PW-1:0] back_full;
  logic [NW-1:0] back_b;
  logic [HW-1:0] qe_b;
  logic [NW-1:0] num_b;
  logic [NW-1:0] rem;
  logic          ge1;
  logic          ge2;
  logic [HW-1:0] qsum;

  // estimate from the truncated numerator, never above the true quotient
  assign est_full  = EW'(num[NW-1:T]) * EW'(MREC);
  assign est_shift = est_full >> (K - T);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      qe_a  <= est_shift[HW-1:0];
      num_a <= num;
    end
  end

  // multiply the estimate back
  assign back_full = PW'(qe_a) * PW'(DIV);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      back_b <= back_full[NW-1:0];
      qe_b   <= qe_a;
      num_b  <= num_a;
    end
  end

  // remainder is below three divisors, so two compares finish the job
  assign rem  = num_b - back_b;
  assign ge1  = rem >= NW'(DIV);
  assign ge2  = rem >= NW'(2 * DIV);
  assign qsum = qe_b + HW'(ge1) + HW'(ge2);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      quo <= QW'(qsum);
    end
  end

endmodule

// ----- hdl/rgblab_root_rom.sv -----
// ---------------------------------------------------------------------------
// rgblab_root_rom: cube-root table, two registered read ports
// Entries are cube roots over [0,2] at a spacing of 2^-R, built at elaboration.
// ---------------------------------------------------------------------------
module rgblab_root_rom #(
  parameter int F = 16,
  parameter int R = 10
) (
  input  logic         clk,
  input  logic         en,
  input  logic [R+1:0] addr0,
  input  logic [R+1:0] addr1,
  output logic [F:0]   data0,
  output logic [F:0]   data1
);

  localparam int DEPTH = (1 << (R + 1)) + 1;

  logic [F:0] rom [DEPTH];

  // constant contents
  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    localparam longint unsigned VAL = rgblab_pkg::root_value(k, F, R);
    assign rom[k] = (F + 1)'(VAL);
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (en) begin
      data0 <= rom[addr0];
      data1 <= rom[addr1];
    end
  end

endmodule

// ----- hdl/rgblab_labf.sv -----
// ---------------------------------------------------------------------------
// rgblab_labf: cielab f() over four pipeline stages
// Linear segment through a divide by 1000, cube root by interpolated table.
// ---------------------------------------------------------------------------
module rgblab_labf #(
  parameter int F = 16,
  parameter int R = 10
) (
  input  logic       clk,
  input  logic [3:0] adv,
  input  logic [F:0] t,
  output logic [F:0] f
);

  localparam longint unsigned TLIM  = (64'd8856 << F) / 1000000;
  localparam int              LW    = $clog2(TLIM + 1);
  localparam int              NWL   = F + 7;
  localparam longint unsigned C16   = ((64'd16 << F) + 58) / 116;
  localparam int              PSW   = F + 1 + R;
  localparam int              DPW   = 2 * F + 1;
  localparam logic [F:0]      T_MAX = (F + 1)'(TLIM);
  localparam logic [F:0]      OFS   = (F + 1)'(C16);

  logic [PSW-1:0] pos;
  logic [R+1:0]   addr0;
  logic [R+1:0]   addr1;
  logic [F:0]     e0;
  logic [F:0]     e1;
  logic           lin_s5;
  logic [NWL-1:0] lnum_s5;
  logic [F-1:0]   frac_s5;
  logic [F:0]     diff;
  logic [DPW-1:0] dprod;
  logic           lin_s6;
  logic [F:0]     e0_s6;
  logic [DPW-1:0] dprod_s6;
  logic           lin_s7;
  logic [F:0]     cube_s7;
  logic           lin_s8;
  logic [F:0]     cube_s8;
  logic [F-1:0]   linq;

  // table position: index in the upper bits, interpolation weight below
  assign pos   = {t, {R{1'b0}}};
  assign addr0 = (R + 2)'(pos[F+R:F]);
  assign addr1 = addr0 + (R + 2)'(1);

  rgblab_root_rom #(
    .F (F),
    .R (R)
  ) u_rom (
    .clk   (clk),
    .en    (adv[0]),
    .addr0 (addr0),
    .addr1 (addr1),
    .data0 (e0),
    .data1 (e1)
  );

  // segment select and linear numerator
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      lin_s5  <= t <= T_MAX;
      lnum_s5 <= NWL'(7787) * NWL'(t[LW-1:0]) + NWL'(500);
      frac_s5 <= pos[F-1:0];
    end
  end

  // linear segment divide
  rgblab_cdiv #(
    .NW  (NWL),
    .DIV (1000),
    .QW  (F)
  ) u_lin_div (
    .clk (clk),
    .adv (adv[3:1]),
    .num (lnum_s5),
    .quo (linq)
  );

  // interpolation product
  assign diff  = (e1 > e0) ? e1 - e0 : '0;
  assign dprod = DPW'(diff) * DPW'(frac_s5);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      lin_s6   <= lin_s5;
      e0_s6    <= e0;
      dprod_s6 <= dprod;
    end
  end

  // interpolated root
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      lin_s7  <= lin_s6;
      cube_s7 <= e0_s6 + dprod_s6[DPW-1:F];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      lin_s8  <= lin_s7;
      cube_s8 <= cube_s7;
    end
  end

  // pick the segment
  assign f = lin_s8 ? (F + 1)'(linq) + OFS : cube_s8;

endmodule

// ----- test/tb_rgb565_to_cielab_top.sv -----
// ---------------------------------------------------------------------------
// tb_rgb565_to_cielab_top: testbench for the rgb565 to cielab converter
// Sends byte-swapped rgb565 pixels over a valid/ready channel, predicts
// L, a and b with an independent fixed-point model of the sRGB D65 path and
// checks every result transaction in order, with random idling on both sides.
// ---------------------------------------------------------------------------
module tb_rgb565_to_cielab_top;

  localparam int FRAC      = 16;
  localparam int ROOT_BITS = 10;
  localparam int ROOT_SIZE = (1 << (ROOT_BITS + 1)) + 1;
  localparam int PIPE_LAT  = 11;
  localparam int RAND_PIXELS = 2000;

  typedef struct packed {
    logic [6:0]        lightness;
    logic signed [7:0] green_red;
    logic signed [7:0] blue_yellow;
  } lab_t;

  typedef struct {
    logic [15:0] px;
    lab_t        lab;
  } pending_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic [15:0]       pixel     = 16'h0000;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [6:0]        lightness;
  logic signed [7:0] green_red;
  logic signed [7:0] blue_yellow;

  // percent of cycles each side holds back
  int idle_pct  = 33;
  int stall_pct = 33;
  int mismatch_count = 0;

  pending_t lab_expected[$];

  // linear channel tables and cube-root table of the prediction
  longint unsigned lin_red_blue[32];
  longint unsigned lin_green[64];
  longint unsigned root_q[ROOT_SIZE];

  rgb565_to_cielab_top DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .lightness   (lightness),
    .green_red   (green_red),
    .blue_yellow (blue_yellow)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- prediction ----

  // q30 to q.frac, rounded half up
  function automatic longint unsigned q30_round(input longint unsigned v);
    return (v + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
  endfunction

  function automatic longint unsigned fifth_pow(input longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  function automatic longint unsigned cubed(input longint unsigned y);
    return (((y * y) >> 30) * y) >> 30;
  endfunction

  // srgb decoding curve of one 8-bit code
  function automatic longint unsigned srgb_linear(input longint unsigned c8);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (c8 <= 64'd10) begin
      return (((c8 * 64'd100) << FRAC) + 64'd164730) / 64'd329460;
    end
    u  = (((64'd1000 * c8 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
    u2 = (u * u) >> 30;
    // largest root whose fifth power fits, so u2 * root ~ u^2.4
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (fifth_pow(mid) <= u2) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return q30_round((u2 * lo) >> 30);
  endfunction

  function automatic void build_lab_tables();
    longint unsigned target;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    for (int k = 0; k < 32; k++) begin
      lin_red_blue[k] = srgb_linear(longint'(k * 255 / 31));
    end
    for (int k = 0; k < 64; k++) begin
      lin_green[k] = srgb_linear(longint'(k * 255 / 63));
    end
    // cube roots over [0,2] in steps of 2^-ROOT_BITS
    for (int k = 0; k < ROOT_SIZE; k++) begin
      target = longint'(k) << (30 - ROOT_BITS);
      lo = 64'd0;
      hi = (64'd1 << 31) - 64'd1;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (cubed(mid) <= target) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
      root_q[k] = q30_round(lo);
    end
  endfunction

  // cielab f(): linear segment near zero, interpolated cube root above
  function automatic longint lab_curve(input longint unsigned t);
    longint unsigned lim;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned e0;
    longint unsigned e1;
    lim = (64'd2 << FRAC) - 64'd1;
    if (t * 64'd1000000 <= (64'd8856 << FRAC)) begin
      return longint'((64'd7787 * t + 64'd500) / 64'd1000 + ((64'd16 << FRAC) + 64'd58) / 64'd116);
    end
    if (t > lim) begin
      t = lim;
    end
    pos  = t << ROOT_BITS;
    idx  = pos >> FRAC;
    frac = pos & ((64'd1 << FRAC) - 64'd1);
    e0   = root_q[idx];
    e1   = root_q[idx + 1];
    if (e1 < e0) begin
      e1 = e0;
    end
    return longint'(e0 + (((e1 - e0) * frac) >> FRAC));
  endfunction

  // floor(v / 2^FRAC + 1/2), floor taken toward minus infinity
  function automatic longint round_lab(input longint v);
    longint s;
    longint unsigned m;
    s = v + longint'(1 << (FRAC - 1));
    if (s >= 0) begin
      return s >>> FRAC;
    end
    m = longint'(-s);
    return -longint'((m + (64'd1 << FRAC) - 64'd1) >> FRAC);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic lab_t predict_lab(input logic [15:0] px);
    longint unsigned rl;
    longint unsigned gl;
    longint unsigned bl;
    longint unsigned x;
    longint unsigned y;
    longint unsigned z;
    longint fx;
    longint fy;
    longint fz;
    longint lv;
    longint av;
    longint bv;
    lab_t res;
    rl = lin_red_blue[px[7:3]];
    gl = lin_green[{px[2:0], px[15:13]}];
    bl = lin_red_blue[px[12:8]];
    // d65 matrix, each row normalized to the white point
    x = ((64'd4124 * rl + 64'd3576 * gl + 64'd1805 * bl) * 64'd10 + 64'd47523) / 64'd95047;
    y = (64'd2126 * rl + 64'd7152 * gl + 64'd722 * bl + 64'd5000) / 64'd10000;
    z = ((64'd193 * rl + 64'd1192 * gl + 64'd9505 * bl) * 64'd10 + 64'd54441) / 64'd108883;
    fx = lab_curve(x);
    fy = lab_curve(y);
    fz = lab_curve(z);
    lv = clip(round_lab(116 * fy - (longint'(16) <<< FRAC)), 0, 100);
    av = clip(round_lab(500 * (fx - fy)), -128, 127);
    bv = clip(round_lab(200 * (fy - fz)), -128, 127);
    res.lightness   = lv[6:0];
    res.green_red   = av[7:0];
    res.blue_yellow = bv[7:0];
    return res;
  endfunction

  // ---- stimulus helpers ----

  // channel codes into the byte-swapped layout
  function automatic logic [15:0] pack_pixel(input logic [4:0] r, input logic [5:0] g,
                                             input logic [4:0] b);
    return {g[2:0], b, r, g[5:3]};
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // one input transaction, with random idle cycles ahead of it
  task automatic send_pixel(input logic [15:0] px);
    pending_t entry;
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= px;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    entry.px  = px;
    entry.lab = predict_lab(px);
    lab_expected.push_back(entry);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    pending_t want;
    if (!rst && out_valid && out_ready) begin
      if (lab_expected.size() == 0) begin
        report_mismatch($sformatf("result L=%0d a=%0d b=%0d with nothing pending",
                                  lightness, green_red, blue_yellow));
      end else begin
        want = lab_expected.pop_front();
        if (lightness !== want.lab.lightness) begin
          report_mismatch($sformatf("pixel %h lightness %0d, want %0d",
                                    want.px, lightness, want.lab.lightness));
        end
        if (green_red !== want.lab.green_red) begin
          report_mismatch($sformatf("pixel %h green_red %0d, want %0d",
                                    want.px, green_red, want.lab.green_red));
        end
        if (blue_yellow !== want.lab.blue_yellow) begin
          report_mismatch($sformatf("pixel %h blue_yellow %0d, want %0d",
                                    want.px, blue_yellow, want.lab.blue_yellow));
        end
      end
    end
  end

  // ---- tests ----

  // primaries, grays, near black and the linear/curve boundaries
  task automatic test_directed_colors();
    send_pixel(pack_pixel(5'd0, 6'd0, 5'd0));     // black
    send_pixel(16'hFFFF);                         // white
    send_pixel(pack_pixel(5'd31, 6'd0, 5'd0));    // red
    send_pixel(pack_pixel(5'd0, 6'd63, 5'd0));    // green
    send_pixel(pack_pixel(5'd0, 6'd0, 5'd31));    // blue
    send_pixel(pack_pixel(5'd31, 6'd0, 5'd31));   // magenta
    send_pixel(pack_pixel(5'd31, 6'd63, 5'd0));   // yellow
    send_pixel(pack_pixel(5'd0, 6'd63, 5'd31));   // cyan
    // near black, L near zero
    send_pixel(pack_pixel(5'd1, 6'd0, 5'd0));
    send_pixel(pack_pixel(5'd0, 6'd1, 5'd0));
    send_pixel(pack_pixel(5'd0, 6'd0, 5'd1));
    // last codes on the linear part of the srgb curve and first past it
    send_pixel(pack_pixel(5'd0, 6'd2, 5'd0));
    send_pixel(pack_pixel(5'd0, 6'd3, 5'd0));
    send_pixel(pack_pixel(5'd2, 6'd0, 5'd0));
    // grays around the f() knee
    send_pixel(pack_pixel(5'd2, 6'd4, 5'd2));
    send_pixel(pack_pixel(5'd3, 6'd6, 5'd3));
    send_pixel(pack_pixel(5'd4, 6'd8, 5'd4));
    send_pixel(pack_pixel(5'd16, 6'd32, 5'd16));
    // raw bit patterns
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    send_pixel(16'h00FF);
    send_pixel(16'hFF00);
  endtask

  // random pixels, part of them built from extreme channel codes
  task automatic test_random_pixels();
    logic [4:0]  r;
    logic [5:0]  g;
    logic [4:0]  b;
    logic [15:0] px;
    for (int n = 0; n < RAND_PIXELS; n++) begin
      // a long stretch with no idling on either side
      if (n >= 700 && n < 1100) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 33;
        stall_pct = 33;
      end
      if ($urandom_range(3, 0) == 0) begin
        case ($urandom_range(3, 0))
          0: r = 5'd0;
          1: r = 5'd1;
          2: r = 5'd31;
          default: r = 5'($urandom);
        endcase
        case ($urandom_range(3, 0))
          0: g = 6'd0;
          1: g = 6'd1;
          2: g = 6'd63;
          default: g = 6'($urandom);
        endcase
        case ($urandom_range(3, 0))
          0: b = 5'd0;
          1: b = 5'd1;
          2: b = 5'd31;
          default: b = 5'($urandom);
        endcase
        px = pack_pixel(r, g, b);
      end else begin
        px = 16'($urandom);
      end
      send_pixel(px);
    end
    idle_pct  = 33;
    stall_pct = 33;
  endtask

  // ---- main sequence ----
  initial begin
    build_lab_tables();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_colors();
    test_random_pixels();
    in_valid <= 1'b0;
    while (lab_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LAT + 5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rgb565_to_cielab_top verification clean");
    end else begin
      $display("rgb565_to_cielab_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("rgb565_to_cielab_top verification failed");
    $finish;
  end

endmodule
